FILE: design/lcf_pkg.sv
`default_nettype none
package lcf_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned COLOR_W   = 4;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 4;

	localparam logic [COLOR_W-1:0] COL_RED     = 4'd0;
	localparam logic [COLOR_W-1:0] COL_GREY    = 4'd1;
	localparam logic [COLOR_W-1:0] COL_BLUE    = 4'd2;
	localparam logic [COLOR_W-1:0] COL_CYAN    = 4'd3;
	localparam logic [COLOR_W-1:0] COL_MAGENTA = 4'd4;
	localparam logic [COLOR_W-1:0] COL_BLACK   = 4'd6;
	localparam logic [COLOR_W-1:0] COL_GREEN   = 4'd7;
	localparam logic [COLOR_W-1:0] COL_WHITE   = 4'd8;
	localparam logic [COLOR_W-1:0] COL_WALL    = 4'd9;
	localparam logic [COLOR_W-1:0] COL_ROBOT   = 4'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PICK_MODE   = 4'd2;

	localparam logic [COLOR_W-1:0] LINE_COLOR_RST  = COL_BLUE;
	localparam logic [COLOR_W-1:0] FLOOR_COLOR_RST = COL_GREY;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [COLOR_W-1:0] color_t;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_MIDDLE = 2'd1,
		ST_WRONG  = 2'd2
	} status_t;

	typedef struct packed {
		color_t target;
		color_t floor_color;
		logic   pick_mode;
	} match_ctl_t;

endpackage
`default_nettype wire

FILE: design/lcf_pixel_if.sv
`default_nettype none
interface lcf_pixel_if
	import lcf_pkg::*;
;
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  wrong_line;
	logic  last_pixel;

	modport source (output valid, output red, output green, output blue,
		output wrong_line, output last_pixel, input ready);
	modport sink (input valid, input red, input green, input blue,
		input wrong_line, input last_pixel, output ready);
endinterface
`default_nettype wire

FILE: design/lcf_result_if.sv
`default_nettype none
interface lcf_result_if
	import lcf_pkg::*;
#(
	parameter int unsigned COL_W = 6
);
	logic             valid;
	logic             ready;
	status_t          status;
	logic [COL_W-1:0] middle_column;

	modport source (output valid, output status, output middle_column, input ready);
	modport sink (input valid, input status, input middle_column, output ready);
endinterface
`default_nettype wire

FILE: design/lcf_cfg_if.sv
`default_nettype none
interface lcf_cfg_if
	import lcf_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DAT_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: design/lcf_color_match.sv
`default_nettype none
module lcf_color_match
	import lcf_pkg::*;
(
	input  wire chan_t      red,
	input  wire chan_t      green,
	input  wire chan_t      blue,
	input  wire match_ctl_t ctl,
	output logic            hit
);

	color_t eff;

	always_comb begin
		eff = ctl.target;
		if (ctl.target == COL_CYAN && ctl.floor_color == COL_GREY && !ctl.pick_mode)
			eff = COL_WHITE;
	end

	always_comb begin
		case (eff)
			COL_RED:     hit = red > 8'd150 && blue < 8'd20 && green < 8'd20;
			COL_GREEN:   hit = green > 8'd150 && blue < 8'd50 && red < 8'd50;
			COL_BLUE:    hit = blue > 8'd150 && red < 8'd50 && green < 8'd50;
			COL_CYAN:    hit = green > 8'd50 && blue > 8'd50 && red < 8'd20;
			COL_MAGENTA: hit = red > 8'd80 && blue > 8'd80 && green < 8'd50;
			COL_BLACK:   hit = red < 8'd10 && green < 8'd10 && blue < 8'd10;
			COL_ROBOT:   hit = (red < 8'd38 && green < 8'd38 && blue < 8'd38
					&& red > 8'd34 && green > 8'd34 && blue > 8'd34)
				|| (red > 8'd100 && red < 8'd200 && green > 8'd100
					&& green < 8'd200 && blue > 8'd100 && blue < 8'd200);
			COL_GREY:    hit = red < 8'd80 && green < 8'd80 && blue < 8'd80
				&& red > 8'd10 && green > 8'd10 && blue > 8'd10;
			COL_WHITE:   hit = red > 8'd150 && blue > 8'd150 && green > 8'd150;
			COL_WALL:    hit = red < 8'd50 && green < 8'd50 && blue < 8'd50;
			default:     hit = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

FILE: design/line_center_finder_unit.sv
`default_nettype none
// A row's last pixel is held in the pixel register, and its row result is then registered in the result register.
// Throughput: one pixel per cycle; the pixel register and the result register
// part the two sides, so a pixel is taken while a finished result waits.
// A stalled result holds back only a row's last pixel.
// Reset (arst_n low): row state cleared, config back to blue line on grey floor.
module line_center_finder_unit
	import lcf_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 64
)(
	input  wire        clk,
	input  wire        arst_n,
	lcf_pixel_if.sink  pix,
	lcf_result_if.source res,
	lcf_cfg_if.sink    cfg
);

	localparam int unsigned COL_W = $clog2(MAX_WIDTH);
	localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);

	color_t line_color_q;
	color_t floor_color_q;
	logic   pick_mode_q;

	logic   valid_s1;
	chan_t  red_s1, green_s1, blue_s1;
	logic   wrong_s1, last_s1;

	logic             in_row_q, row_wrong_q, any_q;
	logic [COL_W-1:0] col_q, first_q, last_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [COL_W-1:0] middle_q;

	logic             fire_s1, out_free, hit;
	logic             row_start, wrong_now, any_in;
	logic [COL_W-1:0] col_now, first_in, first_nx, last_nx, diff, mid;
	match_ctl_t       mctl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_color_q  <= LINE_COLOR_RST;
			floor_color_q <= FLOOR_COLOR_RST;
			pick_mode_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_LINE_COLOR:  line_color_q  <= cfg.wdata;
				CFG_FLOOR_COLOR: floor_color_q <= cfg.wdata;
				CFG_PICK_MODE:   pick_mode_q   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	assign out_free  = !out_valid_q || res.ready;
	assign fire_s1   = valid_s1 && (!last_s1 || out_free);
	assign pix.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (pix.ready)
			valid_s1 <= pix.valid;
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
			wrong_s1 <= pix.wrong_line;
			last_s1  <= pix.last_pixel;
		end
	end

	assign row_start = !in_row_q;
	assign wrong_now = row_start ? wrong_s1 : row_wrong_q;
	assign col_now   = row_start ? '0 : col_q;
	assign any_in    = row_start ? 1'b0 : any_q;
	assign first_in  = row_start ? '0 : first_q;

	always_comb begin
		mctl.target      = line_color_q;
		mctl.floor_color = floor_color_q;
		mctl.pick_mode   = pick_mode_q;
		if (wrong_now)
			mctl.target = (line_color_q == COL_BLUE) ? COL_RED : COL_BLUE;
	end

	lcf_color_match u_match (
		.red   (red_s1),
		.green (green_s1),
		.blue  (blue_s1),
		.ctl   (mctl),
		.hit   (hit)
	);

	assign first_nx = (hit && !any_in) ? col_now : first_in;
	assign last_nx  = hit ? col_now : (row_start ? '0 : last_q);
	assign diff     = last_nx - first_nx;
	assign mid      = first_nx + (diff >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= 1'b0;
			row_wrong_q <= 1'b0;
			any_q       <= 1'b0;
			col_q       <= '0;
			first_q     <= '0;
			last_q      <= '0;
		end else if (fire_s1) begin
			in_row_q    <= !last_s1;
			row_wrong_q <= wrong_now;
			any_q       <= any_in || hit;
			col_q       <= (col_now != COL_MAX) ? col_now + 1'b1 : col_now;
			first_q     <= first_nx;
			last_q      <= last_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire_s1 && last_s1)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			if (!(any_in || hit)) begin
				status_q <= ST_NONE;
				middle_q <= '0;
			end else if (wrong_now) begin
				status_q <= ST_WRONG;
				middle_q <= '0;
			end else begin
				status_q <= ST_MIDDLE;
				middle_q <= mid;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.status        = status_q;
	assign res.middle_column = middle_q;

	a_mid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_MIDDLE |-> middle_q == '0)
		else $error("middle column not zero without a span");

	a_col_sat: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_MAX)
		else $error("column counter past saturation");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> first_q <= last_q)
		else $error("first match after last match");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> out_valid_q && !in_row_q)
		else $error("row end without result");

endmodule
`default_nettype wire
